// File: design/crbf_pkg.sv
// ----------------------------------------------------------------------------
// crbf_pkg: shared types and constants of the RGB565 blit and fill engine
// Opcodes, status codes, sequencer states and sizes used by the engine.
// ----------------------------------------------------------------------------
package crbf_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 128;
    localparam int unsigned DEF_MAX_HEIGHT = 128;

    localparam int unsigned IN_BITS   = 3 + 1 + 16 * 7 + 1;
    localparam int unsigned IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int unsigned OUT_BITS  = 16 + 15 + 2;
    localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_COPY  = 3'd2,
        OP_KEYED = 3'd3,
        OP_FILL  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_CLIPPED = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_DEST_W  = 3'd0,
        REG_DEST_H  = 3'd1,
        REG_SRC_W   = 3'd2,
        REG_SRC_H   = 3'd3,
        REG_CLIP_L  = 3'd4,
        REG_CLIP_T  = 3'd5,
        REG_CLIP_SX = 3'd6,
        REG_CLIP_SY = 3'd7
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_WALK,
        S_DRAIN,
        S_ACCESS,
        S_RESULT
    } t_state;

    // one pixel operation issued by the sequencer to the stores
    typedef struct packed {
        logic src_rd;    // read source store
        logic dst_rd;    // read destination store
        logic src_wr;    // write source store
        logic dst_wr;    // write destination store
    } t_mem_op;

endpackage

// File: design/crbf_store.sv
// ----------------------------------------------------------------------------
// crbf_store: destination and source pixel memories
// Two single-port synchronous memories with a registered read port.
// ----------------------------------------------------------------------------
module crbf_store #(
    parameter int unsigned ADDR_W = 14
) (
    input  logic                i_clk,
    input  crbf_pkg::t_mem_op   i_op,
    input  logic [ADDR_W-1:0]   i_src_addr,
    input  logic [ADDR_W-1:0]   i_dst_addr,
    input  logic [15:0]         i_src_data,
    input  logic [15:0]         i_dst_data,
    output logic [15:0]         o_src_q,
    output logic [15:0]         o_dst_q
);

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic [15:0] r_src_mem [DEPTH];
    logic [15:0] r_dst_mem [DEPTH];
    logic [15:0] r_src_q;
    logic [15:0] r_dst_q;

    always_ff @(posedge i_clk) begin
        if (i_op.src_wr) begin
            r_src_mem[i_src_addr] <= i_src_data;
        end
        if (i_op.src_rd) begin
            r_src_q <= r_src_mem[i_src_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.dst_wr) begin
            r_dst_mem[i_dst_addr] <= i_dst_data;
        end
        if (i_op.dst_rd) begin
            r_dst_q <= r_dst_mem[i_dst_addr];
        end
    end

    assign o_src_q = r_src_q;
    assign o_dst_q = r_dst_q;

endmodule

// File: design/clipped_rgb565_blit_fill_engine.sv
// ----------------------------------------------------------------------------
// clipped_rgb565_blit_fill_engine: clipped copy, keyed copy and fill engine
// A pixel access passes setup, access and drain; copy or fill walks each pixel
// of the clipped window, then drains; fully clipped or no-op goes from setup
// straight to the result. One request at a time; the next is taken in the
// cycle after the result leaves. Reset: synchronous active low; pixel memories not cleared.
// ----------------------------------------------------------------------------
module clipped_rgb565_blit_fill_engine #(
    parameter int unsigned MAX_WIDTH  = crbf_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = crbf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_index,
    input  logic [15:0]                       i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // opcode, surface_sel, color, dest_x, dest_y, rect_x, rect_y,
    // rect_w, rect_h, use_rect
    input  logic [crbf_pkg::IN_BYTES*8-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_pixel, pixels_written, status
    output logic [crbf_pkg::OUT_BYTES*8-1:0]  m_axis_tdata
);

    localparam int unsigned XW     = $clog2(MAX_WIDTH);
    localparam int unsigned YW     = $clog2(MAX_HEIGHT);
    localparam int unsigned ADDR_W = XW + YW;
    localparam logic signed [19:0] MAXW_S = 20'(MAX_WIDTH);
    localparam logic signed [19:0] MAXH_S = 20'(MAX_HEIGHT);

    // configuration
    logic [7:0]         r_dw, r_dh, r_sw, r_sh;
    logic signed [15:0] r_cl, r_ct, r_csx, r_csy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dw  <= 8'd128;
            r_dh  <= 8'd128;
            r_sw  <= 8'd128;
            r_sh  <= 8'd128;
            r_cl  <= '0;
            r_ct  <= '0;
            r_csx <= 16'sd128;
            r_csy <= 16'sd128;
        end else if (i_cfg_we) begin
            case (crbf_pkg::t_reg'(i_cfg_index))
                crbf_pkg::REG_DEST_W:  r_dw  <= i_cfg_data[7:0];
                crbf_pkg::REG_DEST_H:  r_dh  <= i_cfg_data[7:0];
                crbf_pkg::REG_SRC_W:   r_sw  <= i_cfg_data[7:0];
                crbf_pkg::REG_SRC_H:   r_sh  <= i_cfg_data[7:0];
                crbf_pkg::REG_CLIP_L:  r_cl  <= i_cfg_data;
                crbf_pkg::REG_CLIP_T:  r_ct  <= i_cfg_data;
                crbf_pkg::REG_CLIP_SX: r_csx <= i_cfg_data;
                crbf_pkg::REG_CLIP_SY: r_csy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic signed [19:0] f_dim(input logic [7:0] v,
                                                 input logic signed [19:0] lim);
        logic signed [19:0] d;
        d = 20'(v);
        return (d > lim) ? lim : d;
    endfunction

    function automatic logic signed [19:0] f_max(input logic signed [19:0] a,
                                                 input logic signed [19:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [19:0] f_min(input logic signed [19:0] a,
                                                 input logic signed [19:0] b);
        return (a < b) ? a : b;
    endfunction

    // request fields
    logic [2:0]         r_op;
    logic               r_sel, r_use;
    logic [15:0]        r_color;
    logic signed [15:0] r_dx, r_dy, r_rx, r_ry, r_rw, r_rh;

    crbf_pkg::t_state r_state, n_state;

    // walk window
    logic signed [19:0] r_ax0, r_ay0, r_ax1, r_ay1, r_sx0, r_sy0;
    logic [XW:0]        r_cx;
    logic [YW:0]        r_cy;
    logic [15:0]        r_count;
    logic               r_pv;          // source read in flight
    logic [ADDR_W-1:0]  r_pdst;
    logic [15:0]        r_rd;
    logic [1:0]         r_status;
    logic [14:0]        out_cnt;

    // setup arithmetic (registered at end of S_SETUP)
    logic signed [19:0] dw, dh, srw, srh, sdw, sdh;
    logic signed [19:0] sx, sy, sw, sh, dxx, dyy;
    logic signed [19:0] c0, c1, c2, c3, ax0, ay0, ax1, ay1;
    logic               empty;

    always_comb begin
        dw  = f_dim(r_dw, MAXW_S);
        dh  = f_dim(r_dh, MAXH_S);
        srw = f_dim(r_sw, MAXW_S);
        srh = f_dim(r_sh, MAXH_S);
        c0 = f_max(20'(r_cl), '0);
        c1 = f_max(20'(r_ct), '0);
        c2 = f_min(20'(r_cl) + 20'(r_csx), dw);
        c3 = f_min(20'(r_ct) + 20'(r_csy), dh);
        dxx = 20'(r_dx);
        dyy = 20'(r_dy);
        sx = '0; sy = '0; sw = srw; sh = srh;
        sdw = '0; sdh = '0;
        if (r_op == crbf_pkg::OP_FILL) begin
            ax0 = '0; ay0 = '0; ax1 = dw; ay1 = dh;
            if (r_use) begin
                ax0 = 20'(r_rx);
                ay0 = 20'(r_ry);
                ax1 = 20'(r_rx) + 20'(r_rw);
                ay1 = 20'(r_ry) + 20'(r_rh);
            end
            ax0 = f_max(ax0, c0);
            ay0 = f_max(ay0, c1);
            ax1 = f_min(ax1, c2);
            ay1 = f_min(ay1, c3);
            empty = (ax0 >= ax1) || (ay0 >= ay1);
        end else begin
            if (r_use) begin
                sx = 20'(r_rx); sy = 20'(r_ry);
                sw = 20'(r_rw); sh = 20'(r_rh);
            end
            if (sx < 0) begin
                dxx = dxx - sx; sw = sw + sx; sx = '0;
            end
            if (sy < 0) begin
                dyy = dyy - sy; sh = sh + sy; sy = '0;
            end
            if (sx + sw > srw) sw = srw - sx;
            if (sy + sh > srh) sh = srh - sy;
            ax0 = f_max(dxx, c0);
            ay0 = f_max(dyy, c1);
            ax1 = f_min(dxx + sw, c2);
            ay1 = f_min(dyy + sh, c3);
            sdw = sx + (ax0 - dxx);
            sdh = sy + (ay0 - dyy);
            empty = (sw <= 0) || (sh <= 0) || (c0 >= c2) || (c1 >= c3)
                 || (ax0 >= ax1) || (ay0 >= ay1);
        end
    end

    // pixel walk addressing
    logic signed [19:0] wx, wy, swx, swy;
    logic               last_x, last_y, in_src;
    logic [ADDR_W-1:0]  waddr_d, waddr_s;

    assign wx  = r_ax0 + 20'(r_cx);
    assign wy  = r_ay0 + 20'(r_cy);
    assign swx = r_sx0 + 20'(r_cx);
    assign swy = r_sy0 + 20'(r_cy);
    assign last_x  = (wx + 20'sd1) >= r_ax1;
    assign last_y  = (wy + 20'sd1) >= r_ay1;
    assign in_src  = (swx < MAXW_S) && (swy < MAXH_S);
    assign waddr_d = {wy[YW-1:0], wx[XW-1:0]};
    assign waddr_s = {swy[YW-1:0], swx[XW-1:0]};

    // pixel access
    logic signed [19:0] pw, ph, px, py;
    logic               p_ok;
    logic [ADDR_W-1:0]  paddr;

    assign pw = r_sel ? f_dim(r_sw, MAXW_S) : f_dim(r_dw, MAXW_S);
    assign ph = r_sel ? f_dim(r_sh, MAXH_S) : f_dim(r_dh, MAXH_S);
    assign px = 20'(r_dx);
    assign py = 20'(r_dy);
    assign p_ok  = (px >= 0) && (py >= 0) && (px < pw) && (py < ph);
    assign paddr = {py[YW-1:0], px[XW-1:0]};

    // store
    crbf_pkg::t_mem_op  mop;
    logic [ADDR_W-1:0]  src_addr, dst_addr;
    logic [15:0]        src_wd, dst_wd, src_q, dst_q;
    logic               keep;

    assign keep = (r_op != crbf_pkg::OP_KEYED) || (src_q != r_color);

    always_comb begin
        mop      = '0;
        src_addr = waddr_s;
        dst_addr = r_pdst;
        src_wd   = r_color;
        dst_wd   = (r_op == crbf_pkg::OP_FILL) ? r_color : src_q;
        if (r_state == crbf_pkg::S_ACCESS) begin
            src_addr = paddr;
            dst_addr = paddr;
            dst_wd   = r_color;
            if (p_ok) begin
                mop.src_wr = (r_op == crbf_pkg::OP_WRITE) && r_sel;
                mop.dst_wr = (r_op == crbf_pkg::OP_WRITE) && !r_sel;
                mop.src_rd = (r_op == crbf_pkg::OP_READ) && r_sel;
                mop.dst_rd = (r_op == crbf_pkg::OP_READ) && !r_sel;
            end
        end else if (r_state == crbf_pkg::S_WALK
                     && r_op == crbf_pkg::OP_FILL) begin
            dst_addr   = waddr_d;
            mop.dst_wr = 1'b1;
        end else begin
            mop.src_rd = (r_state == crbf_pkg::S_WALK) && in_src;
            mop.dst_wr = r_pv && keep;
        end
    end

    crbf_store #(.ADDR_W(ADDR_W)) u_store (
        .i_clk      (i_clk),
        .i_op       (mop),
        .i_src_addr (src_addr),
        .i_dst_addr (dst_addr),
        .i_src_data (src_wd),
        .i_dst_data (dst_wd),
        .o_src_q    (src_q),
        .o_dst_q    (dst_q)
    );

    logic accept_in, out_take;
    assign accept_in     = s_axis_tvalid && s_axis_tready;
    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == crbf_pkg::S_IDLE);
    assign m_axis_tvalid = (r_state == crbf_pkg::S_RESULT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            crbf_pkg::S_IDLE: if (accept_in) n_state = crbf_pkg::S_SETUP;
            crbf_pkg::S_SETUP: begin
                if (r_op == crbf_pkg::OP_WRITE || r_op == crbf_pkg::OP_READ) begin
                    n_state = crbf_pkg::S_ACCESS;
                end else if (r_op == crbf_pkg::OP_COPY || r_op == crbf_pkg::OP_KEYED
                             || r_op == crbf_pkg::OP_FILL) begin
                    n_state = empty ? crbf_pkg::S_RESULT : crbf_pkg::S_WALK;
                end else begin
                    n_state = crbf_pkg::S_RESULT;
                end
            end
            crbf_pkg::S_WALK:  if (last_x && last_y) n_state = crbf_pkg::S_DRAIN;
            crbf_pkg::S_DRAIN: n_state = crbf_pkg::S_RESULT;
            crbf_pkg::S_ACCESS: n_state = crbf_pkg::S_DRAIN;
            crbf_pkg::S_RESULT: if (out_take) n_state = crbf_pkg::S_IDLE;
            default: n_state = crbf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crbf_pkg::S_IDLE;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == crbf_pkg::S_WALK) && in_src
                    && (r_op != crbf_pkg::OP_FILL);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pdst <= waddr_d;
        case (r_state)
            crbf_pkg::S_IDLE: begin
                if (accept_in) begin
                    r_op    <= s_axis_tdata[2:0];
                    r_sel   <= s_axis_tdata[3];
                    r_color <= s_axis_tdata[19:4];
                    r_dx    <= s_axis_tdata[35:20];
                    r_dy    <= s_axis_tdata[51:36];
                    r_rx    <= s_axis_tdata[67:52];
                    r_ry    <= s_axis_tdata[83:68];
                    r_rw    <= s_axis_tdata[99:84];
                    r_rh    <= s_axis_tdata[115:100];
                    r_use   <= s_axis_tdata[116];
                end
            end
            crbf_pkg::S_SETUP: begin
                r_ax0    <= ax0;
                r_ay0    <= ay0;
                r_ax1    <= ax1;
                r_ay1    <= ay1;
                r_sx0    <= sdw;
                r_sy0    <= sdh;
                r_cx     <= '0;
                r_cy     <= '0;
                r_count  <= '0;
                r_rd     <= '0;
                r_status <= (empty && (r_op == crbf_pkg::OP_COPY
                                       || r_op == crbf_pkg::OP_KEYED
                                       || r_op == crbf_pkg::OP_FILL))
                          ? crbf_pkg::ST_CLIPPED : crbf_pkg::ST_DONE;
            end
            crbf_pkg::S_WALK: begin
                if (last_x) begin
                    r_cx <= '0;
                    r_cy <= r_cy + (YW+1)'(1);
                end else begin
                    r_cx <= r_cx + (XW+1)'(1);
                end
                if (r_op == crbf_pkg::OP_FILL) r_count <= r_count + 16'd1;
            end
            crbf_pkg::S_ACCESS: begin
                if (!p_ok) begin
                    r_status <= crbf_pkg::ST_RANGE;
                end else if (r_op == crbf_pkg::OP_WRITE && !r_sel) begin
                    r_count <= 16'd1;
                end
            end
            crbf_pkg::S_DRAIN: begin
                if (r_op == crbf_pkg::OP_READ && p_ok) begin
                    r_rd <= r_sel ? src_q : dst_q;
                end
            end
            default: ;
        endcase
        if (r_pv && keep && r_op != crbf_pkg::OP_FILL) r_count <= r_count + 16'd1;
    end

    assign out_cnt = (r_count > 16'h7FFF) ? 15'h7FFF : r_count[14:0];
    assign m_axis_tdata = {{(crbf_pkg::OUT_BYTES*8-crbf_pkg::OUT_BITS){1'b0}},
                           r_status, out_cnt, r_rd};

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("request taken while result pending");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == crbf_pkg::S_IDLE || r_state == crbf_pkg::S_RESULT)
        |-> !mop.dst_wr && !mop.src_wr)
        else $error("store write outside command");
    a_clip_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_status == crbf_pkg::ST_CLIPPED) |-> r_count == 16'd0)
        else $error("clipped command wrote pixels");
`endif

endmodule
